// File: design/lfpd_pkg.sv
package lfpd_pkg;

   // field widths
   localparam int SENSOR_W = 8;
   localparam int GAIN_W   = 16;
   localparam int SPEED_W  = 11;
   localparam int DIR_W    = 2;
   localparam int CSR_IDX_W = 2;

   // error path
   localparam int SUM_W    = 6;   // signed weight sum, |sum| <= 23
   localparam int CNT_W    = 4;   // sensors seen, 1..8
   localparam int DVD_W    = 13;  // |sum| * 256
   localparam int ERR_W    = 14;  // signed q8 line error
   localparam int DIFF_W   = 15;  // signed error difference

   // multiply-accumulate path
   localparam int ACC_W    = 32;
   localparam int MSTEP_W  = 4;
   localparam int DRV_W    = 16;
   localparam int LR_W     = 17;

   localparam logic [ACC_W-1:0]   TRUNC_BIAS  = 32'h0000_FFFF;
   localparam logic signed [LR_W-1:0] SPEED_MAX = 17'sd999;
   localparam logic signed [LR_W-1:0] SPEED_MIN = -17'sd999;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PROP_GAIN  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DERIV_GAIN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_SPEED = 2'd2;

   // direction codes
   localparam logic [DIR_W-1:0] DIR_STOP     = 2'd0;
   localparam logic [DIR_W-1:0] DIR_STRAIGHT = 2'd1;
   localparam logic [DIR_W-1:0] DIR_RIGHT    = 2'd2;
   localparam logic [DIR_W-1:0] DIR_LEFT     = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_MAC,
      ST_DRIVE,
      ST_SPEED
   } lfpd_state_type;

   // weight of each sensor, index = bit number (bit 7 leftmost)
   localparam logic signed [SUM_W-1:0] SENSOR_WEIGHT [SENSOR_W] = '{
      6'sd13, 6'sd6, 6'sd3, 6'sd1, -6'sd1, -6'sd3, -6'sd6, -6'sd13
   };

endpackage

// File: design/lfpd_divider.sv
module lfpd_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [lfpd_pkg::DVD_W-1:0]    dividend,
   input  logic [lfpd_pkg::CNT_W-1:0]    divisor,
   input  logic                          neg,
   output logic                          done,
   output logic signed [lfpd_pkg::ERR_W-1:0] quotient
);
   import lfpd_pkg::*;

   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DVD_W - 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVD_W-1:0] q_ff, q_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] div_ff, div_in;
   logic             neg_ff, neg_in;

   logic [CNT_W:0]   trial;
   logic [CNT_W:0]   diff;
   logic             fits;

   // restoring division, one quotient bit per cycle
   always_comb begin
      trial = {rem_ff, q_ff[DVD_W-1]};
      diff  = trial - {1'b0, div_ff};
      fits  = (trial >= {1'b0, div_ff});

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      neg_in  = neg_ff;

      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         q_in    = dividend;
         rem_in  = '0;
         div_in  = divisor;
         neg_in  = neg;
      end else if (busy_ff) begin
         rem_in = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
         q_in   = {q_ff[DVD_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed({1'b0, q_ff}) : $signed({1'b0, q_ff});

endmodule

// File: design/lfpd_mac.sv
module lfpd_mac (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [lfpd_pkg::GAIN_W-1:0]   prop_gain,
   input  logic signed [lfpd_pkg::GAIN_W-1:0]   deriv_gain,
   input  logic signed [lfpd_pkg::ERR_W-1:0]    err,
   input  logic signed [lfpd_pkg::ERR_W-1:0]    prev_err,
   output logic                                 done,
   output logic signed [lfpd_pkg::ACC_W-1:0]    acc
);
   import lfpd_pkg::*;

   localparam logic [MSTEP_W-1:0] LAST_STEP = MSTEP_W'(DIFF_W - 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              phase_ff, phase_in;
   logic [MSTEP_W-1:0] cnt_ff, cnt_in;
   logic [ACC_W-1:0]  mcand_ff, mcand_in;
   logic [DIFF_W-1:0] mplier_ff, mplier_in;
   logic [DIFF_W-1:0] diff_ff, diff_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [ACC_W-1:0]  addend;

   // shift-add multiply, one multiplier bit per cycle; kp*e then kd*(e - prev)
   always_comb begin
      addend = mplier_ff[0] ? mcand_ff : '0;

      busy_in   = busy_ff;
      done_in   = 1'b0;
      phase_in  = phase_ff;
      cnt_in    = cnt_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      diff_in   = diff_ff;
      acc_in    = acc_ff;

      if (start) begin
         busy_in   = 1'b1;
         phase_in  = 1'b0;
         cnt_in    = '0;
         mcand_in  = ACC_W'(prop_gain);
         mplier_in = DIFF_W'(err);
         diff_in   = DIFF_W'(err) - DIFF_W'(prev_err);
         acc_in    = '0;
      end else if (busy_ff) begin
         // sign bit of the multiplier carries negative weight
         acc_in    = (cnt_ff == LAST_STEP) ? acc_ff - addend : acc_ff + addend;
         mcand_in  = {mcand_ff[ACC_W-2:0], 1'b0};
         mplier_in = {1'b0, mplier_ff[DIFF_W-1:1]};
         cnt_in    = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            cnt_in = '0;
            if (!phase_ff) begin
               phase_in  = 1'b1;
               mcand_in  = ACC_W'(deriv_gain);
               mplier_in = diff_ff;
            end else begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      phase_ff  <= phase_in;
      cnt_ff    <= cnt_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      diff_ff   <= diff_in;
      acc_ff    <= acc_in;
   end

   assign done = done_ff;
   assign acc  = $signed(acc_ff);

endmodule

// File: design/line_follow_pd_steering_unit.sv
// channel   dir   handshake              payload
// req       in    req_tvalid/req_tready  tdata: sensor_bits
// rsp       out   rsp_tvalid/rsp_tready  tdata: direction, chan1_compare, chan2_compare
// csr       in    csr_wen                csr_index, csr_wdata
//
// a sample with a line runs through the bit-serial error divider, then the shift-add
//   pd multiply (15 bits of e, then 15 bits of e - prev), then the drive and speed stages
// a sample with no line seen skips the divider and multiply and goes straight to the speed stage
// one request is in flight at a time; the next is taken as soon as the result is registered
// a stalled result holds in the output register and holds back only the final stage
// reset is synchronous: gains, base speed and last error clear to zero
module line_follow_pd_steering_unit (
   input  logic                               clock,
   input  logic                               reset,
   // request
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,  // [7:0] sensor_bits
   // result
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [23:0]                        rsp_tdata,  // [1:0] direction,
                                                          // [12:2] chan1_compare,
                                                          // [23:13] chan2_compare
   // configuration
   input  logic                               csr_wen,
   input  logic [lfpd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [lfpd_pkg::GAIN_W-1:0]        csr_wdata
);
   import lfpd_pkg::*;

   lfpd_state_type state_ff, state_in;

   // configuration and loop state
   logic signed [GAIN_W-1:0]  kp_ff, kd_ff;
   logic signed [SPEED_W-1:0] base_ff;
   logic signed [ERR_W-1:0]   prev_err_ff, prev_err_in;

   // per request
   logic                      no_line_ff, no_line_in;
   logic signed [DRV_W-1:0]   drive_ff, drive_in;

   // result register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [DIR_W-1:0]          dir_ff, dir_in;
   logic [SPEED_W-1:0]        ch1_ff, ch1_in;
   logic [SPEED_W-1:0]        ch2_ff, ch2_in;

   logic                      req_accept;
   logic                      rsp_free;

   // weighted sum and count of sensors seen
   logic signed [SUM_W-1:0]   wsum;
   logic [CNT_W-1:0]          seen;
   logic [SUM_W-1:0]          wsum_mag;

   logic                      div_start, div_done;
   logic signed [ERR_W-1:0]   div_err;
   logic                      mac_start, mac_done;
   logic signed [ACC_W-1:0]   mac_acc;
   logic [ACC_W-1:0]          acc_adj;

   logic signed [LR_W-1:0]    left_raw, right_raw;
   logic signed [LR_W-1:0]    left_sat, right_sat;

   assign req_accept = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      wsum = '0;
      seen = '0;
      for (int i = 0; i < SENSOR_W; i++) begin
         if (req_tdata[i]) begin
            wsum = wsum + SENSOR_WEIGHT[i];
            seen = seen + 1'b1;
         end
      end
      wsum_mag = wsum[SUM_W-1] ? -wsum : wsum;
   end

   assign div_start = req_accept && (req_tdata != '0);
   assign mac_start = (state_ff == ST_DIV) && div_done;

   lfpd_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({wsum_mag[SUM_W-2:0], 8'h00}),
      .divisor  (seen),
      .neg      (wsum[SUM_W-1]),
      .done     (div_done),
      .quotient (div_err)
   );

   lfpd_mac u_mac (
      .clock      (clock),
      .reset      (reset),
      .start      (mac_start),
      .prop_gain  (kp_ff),
      .deriv_gain (kd_ff),
      .err        (div_err),
      .prev_err   (prev_err_ff),
      .done       (mac_done),
      .acc        (mac_acc)
   );

   // q16 sum to integer, truncated toward zero
   assign acc_adj = mac_acc[ACC_W-1] ? (ACC_W'(mac_acc) + TRUNC_BIAS) : ACC_W'(mac_acc);

   // wheel speeds with clamp
   always_comb begin
      left_raw  = LR_W'(base_ff) + LR_W'(drive_ff);
      right_raw = LR_W'(base_ff) - LR_W'(drive_ff);
      left_sat  = (left_raw > SPEED_MAX) ? SPEED_MAX :
                  (left_raw < SPEED_MIN) ? SPEED_MIN : left_raw;
      right_sat = (right_raw > SPEED_MAX) ? SPEED_MAX :
                  (right_raw < SPEED_MIN) ? SPEED_MIN : right_raw;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      req_tready   = 1'b0;
      no_line_in   = no_line_ff;
      drive_in     = drive_ff;
      prev_err_in  = prev_err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      dir_in       = dir_ff;
      ch1_in       = ch1_ff;
      ch2_in       = ch2_ff;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               no_line_in = (req_tdata == '0);
               state_in   = (req_tdata == '0) ? ST_SPEED : ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               prev_err_in = div_err;
               state_in    = ST_MAC;
            end
         end
         ST_MAC: begin
            if (mac_done) begin
               state_in = ST_DRIVE;
            end
         end
         ST_DRIVE: begin
            drive_in = acc_adj[ACC_W-1 -: DRV_W];
            state_in = ST_SPEED;
         end
         ST_SPEED: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (no_line_ff || left_sat == '0 || right_sat == '0) begin
                  dir_in = DIR_STOP;
                  ch1_in = '0;
                  ch2_in = '0;
               end else if (left_sat == right_sat) begin
                  dir_in = DIR_STRAIGHT;
                  ch1_in = left_sat[SPEED_W-1:0];
                  ch2_in = right_sat[SPEED_W-1:0];
               end else begin
                  // channels swap on turns
                  dir_in = (left_sat > right_sat) ? DIR_RIGHT : DIR_LEFT;
                  ch1_in = right_sat[SPEED_W-1:0];
                  ch2_in = left_sat[SPEED_W-1:0];
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // any valid register write restarts the derivative term
      if (csr_wen && (csr_index == CSR_PROP_GAIN || csr_index == CSR_DERIV_GAIN ||
                      csr_index == CSR_BASE_SPEED)) begin
         prev_err_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         kp_ff        <= '0;
         kd_ff        <= '0;
         base_ff      <= '0;
         prev_err_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         prev_err_ff  <= prev_err_in;
         if (csr_wen) begin
            unique case (csr_index)
               CSR_PROP_GAIN:  kp_ff   <= csr_wdata;
               CSR_DERIV_GAIN: kd_ff   <= csr_wdata;
               CSR_BASE_SPEED: base_ff <= csr_wdata[SPEED_W-1:0];
               default: ;
            endcase
         end
      end
      no_line_ff <= no_line_in;
      drive_ff   <= drive_in;
      dir_ff     <= dir_in;
      ch1_ff     <= ch1_in;
      ch2_ff     <= ch2_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {ch2_ff, ch1_ff, dir_ff};

endmodule

// File: design/lfpd_checker.sv
module lfpd_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [23:0]                        rsp_tdata
);
   import lfpd_pkg::*;

   // no result straight out of reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // one request at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // stop carries zero compares
   a_stop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] == DIR_STOP |-> rsp_tdata[23:2] == '0)
      else $error("stop with nonzero compare");

   // straight carries equal nonzero compares
   a_straight_equal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] == DIR_STRAIGHT
      |-> rsp_tdata[12:2] == rsp_tdata[23:13] && rsp_tdata[12:2] != '0)
      else $error("straight with unequal or zero compares");

endmodule

bind line_follow_pd_steering_unit lfpd_checker u_lfpd_checker (.*);

// File: tb/sv/line_follow_pd_steering_unit_test.sv
`timescale 1ns / 1ps

module line_follow_pd_steering_unit_test;
   import lfpd_pkg::*;

   // unused register index, writes there must be ignored
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   // margin that covers any leftover work in the block
   localparam int SETTLE_CYCLES = 60;

   typedef struct packed {
      logic [DIR_W-1:0]   direction;
      logic [SPEED_W-1:0] chan1;
      logic [SPEED_W-1:0] chan2;
   } steer_type;

   typedef enum logic {ROW_CSR, ROW_SAMPLE} row_kind_type;

   typedef struct {
      row_kind_type       kind;
      logic [CSR_IDX_W-1:0] idx;
      logic [GAIN_W-1:0]  data;
      logic [SENSOR_W-1:0] bits;
      bit                 typed;
      steer_type          want;
   } stim_row_type;

   logic clock;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [7:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic csr_wen = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [GAIN_W-1:0] csr_wdata = '0;

   // steering model state and register copies
   logic signed [GAIN_W-1:0]  prop_gain;
   logic signed [GAIN_W-1:0]  deriv_gain;
   logic signed [SPEED_W-1:0] base_speed;
   logic signed [ERR_W-1:0]   line_err;

   steer_type    steer_due[$];   // predicted results, oldest first
   stim_row_type script[$];      // directed stimulus
   int        faults = 0;
   bit        calm = 1'b0;    // no idling on either side while set
   int        stall_left = 0;

   line_follow_pd_steering_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // weighted mean of the lit sensors, then pd drive, clamped wheel speeds
   function automatic steer_type predict_steering(input logic [SENSOR_W-1:0] bits);
      int lane_weight [8] = '{13, 6, 3, 1, -1, -3, -6, -13};
      int wsum, lit, err;
      longint acc, drive, left, right;
      steer_type r;
      r = '{DIR_STOP, '0, '0};
      if (bits == '0) return r;   // no line: stop, last error kept
      wsum = 0;
      lit = 0;
      for (int i = 0; i < SENSOR_W; i++) begin
         if (bits[i]) begin
            wsum += lane_weight[i];
            lit++;
         end
      end
      err = (wsum * 256) / lit;   // q8, truncated toward zero
      acc = longint'(prop_gain) * err + longint'(deriv_gain) * (err - int'(line_err));
      drive = acc / 65536;        // q16 down to integer, toward zero
      line_err = ERR_W'(err);
      left = longint'(base_speed) + drive;
      right = longint'(base_speed) - drive;
      if (left > 999) left = 999;
      if (left < -999) left = -999;
      if (right > 999) right = 999;
      if (right < -999) right = -999;
      // a stopped wheel stops both
      if (left == 0 || right == 0) return r;
      if (left == right) begin
         r = '{DIR_STRAIGHT, SPEED_W'(left), SPEED_W'(right)};
      end else begin
         // channels swap on turns
         r.direction = (left > right) ? DIR_RIGHT : DIR_LEFT;
         r.chan1 = SPEED_W'(right);
         r.chan2 = SPEED_W'(left);
      end
      return r;
   endfunction

   // mostly a narrow line under one to three adjacent sensors
   function automatic logic [SENSOR_W-1:0] pick_sensors();
      int r, w;
      r = $urandom_range(99);
      if (r < 5) return 8'h00;
      if (r < 75) begin
         w = $urandom_range(1, 3);
         return 8'((1 << w) - 1) << $urandom_range(0, 8 - w);
      end
      return 8'($urandom_range(255));
   endfunction

   function automatic logic [GAIN_W-1:0] pick_gain();
      int r;
      r = $urandom_range(99);
      if (r < 70) return GAIN_W'($urandom_range(0, 8191) - 4096);
      if (r < 85) return GAIN_W'($urandom_range(16'hFFFF));
      case ($urandom_range(2))
         0: return 16'h7FFF;
         1: return 16'h8000;
         default: return 16'h0000;
      endcase
   endfunction

   function automatic logic [GAIN_W-1:0] pick_base();
      int r;
      r = $urandom_range(99);
      if (r < 70) return GAIN_W'($urandom_range(0, 1998) - 999);
      // patterns beyond +-999 go straight into the sum
      if (r < 85) return GAIN_W'($urandom_range(16'hFFFF));
      case ($urandom_range(2))
         0: return GAIN_W'(999);
         1: return GAIN_W'(-999);
         default: return 16'h0000;
      endcase
   endfunction

   task automatic add_write(input logic [CSR_IDX_W-1:0] idx, input logic [GAIN_W-1:0] data);
      script.push_back('{ROW_CSR, idx, data, 8'h00, 1'b0, '0});
   endtask

   task automatic add_sample(input logic [SENSOR_W-1:0] bits);
      script.push_back('{ROW_SAMPLE, CSR_PROP_GAIN, '0, bits, 1'b0, '0});
   endtask

   task automatic add_known(input logic [SENSOR_W-1:0] bits, input logic [DIR_W-1:0] dir,
                            input logic [SPEED_W-1:0] c1, input logic [SPEED_W-1:0] c2);
      script.push_back('{ROW_SAMPLE, CSR_PROP_GAIN, '0, bits, 1'b1, '{dir, c1, c2}});
   endtask

   // only used while the block is idle
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [GAIN_W-1:0] data);
      @(posedge clock);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wen <= 1'b0;
      case (idx)
         CSR_PROP_GAIN: begin
            prop_gain = data;
            line_err = '0;
         end
         CSR_DERIV_GAIN: begin
            deriv_gain = data;
            line_err = '0;
         end
         CSR_BASE_SPEED: begin
            base_speed = data[SPEED_W-1:0];
            line_err = '0;
         end
         default: ;   // unused index leaves everything alone
      endcase
   endtask

   // one request; park drops valid afterwards, otherwise it may stay high
   task automatic send_sample(input logic [SENSOR_W-1:0] bits, input bit typed,
                              input steer_type want, input bit park);
      steer_type guess;
      req_tvalid <= 1'b1;
      req_tdata <= bits;
      do @(posedge clock); while (!req_tready);
      guess = predict_steering(bits);
      steer_due.push_back(typed ? want : guess);
      if (park || (!calm && $urandom_range(99) < 19)) begin
         req_tvalid <= 1'b0;
         if (!park) repeat ($urandom_range(1, 40)) @(posedge clock);
      end
   endtask

   // wait for every outstanding result, then let the block settle
   task automatic quiesce();
      while (steer_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // result side: random ready, with an occasional long stall
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!calm && $urandom_range(999) < 3) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(20, 80);
      end else begin
         rsp_tready <= calm || ($urandom_range(99) >= 19);
      end
   end

   // compare each accepted result with the oldest prediction
   always @(posedge clock) begin
      steer_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata[1:0], rsp_tdata[12:2], rsp_tdata[23:13]};
         if (steer_due.size() == 0) begin
            $error("result with none pending: %h", rsp_tdata);
            faults++;
         end else begin
            want = steer_due.pop_front();
            if (got.direction !== want.direction) begin
               $error("direction: expected %0d, got %0d", want.direction, got.direction);
               faults++;
            end
            if (got.chan1 !== want.chan1) begin
               $error("chan1_compare: expected %0d, got %0d",
                      $signed(want.chan1), $signed(got.chan1));
               faults++;
            end
            if (got.chan2 !== want.chan2) begin
               $error("chan2_compare: expected %0d, got %0d",
                      $signed(want.chan2), $signed(got.chan2));
               faults++;
            end
         end
      end
   end

   initial begin
      logic [CSR_IDX_W-1:0] reg_order [3];
      int rot;
      bit park;

      prop_gain = '0;
      deriv_gain = '0;
      base_speed = '0;
      line_err = '0;
      reg_order = '{CSR_PROP_GAIN, CSR_DERIV_GAIN, CSR_BASE_SPEED};

      // everything zero after reset: every sample stops
      add_known(8'h00, DIR_STOP, '0, '0);
      add_known(8'h80, DIR_STOP, '0, '0);
      add_known(8'hFF, DIR_STOP, '0, '0);
      // gain 1.0, damping 0.5, cruise 500
      add_write(CSR_PROP_GAIN, 16'h0100);
      add_write(CSR_DERIV_GAIN, 16'h0080);
      add_write(CSR_BASE_SPEED, 16'd500);
      add_known(8'h18, DIR_STRAIGHT, 11'd500, 11'd500);   // centered line
      add_sample(8'h80);
      add_sample(8'h01);
      add_known(8'h00, DIR_STOP, '0, '0);                 // line lost
      add_sample(8'h55);
      add_sample(8'hAA);
      add_sample(8'hFF);
      // right wheel lands on exactly zero
      add_write(CSR_DERIV_GAIN, 16'h0000);
      add_write(CSR_BASE_SPEED, 16'd13);
      add_sample(8'h01);
      // extreme gains, base above the clamp
      add_write(CSR_PROP_GAIN, 16'h7FFF);
      add_write(CSR_DERIV_GAIN, 16'h8000);
      add_write(CSR_BASE_SPEED, 16'h03FF);
      add_sample(8'h80);
      add_sample(8'h01);
      add_sample(8'h80);
      // most negative base pattern
      add_write(CSR_BASE_SPEED, 16'h0400);
      add_sample(8'h01);
      add_sample(8'h80);
      // tiny gain: negative drive must truncate toward zero
      add_write(CSR_PROP_GAIN, 16'h0001);
      add_write(CSR_DERIV_GAIN, 16'h0100);
      add_write(CSR_BASE_SPEED, 16'd100);
      add_sample(8'h80);
      // write to the unused index keeps the last error
      add_write(CSR_UNUSED, 16'hFFFF);
      add_sample(8'h07);
      add_write(CSR_PROP_GAIN, 16'h8000);
      add_write(CSR_BASE_SPEED, -16'sd999);
      add_sample(8'h80);
      add_sample(8'h01);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < script.size(); i++) begin
         if (script[i].kind == ROW_CSR) begin
            quiesce();
            csr_write(script[i].idx, script[i].data);
         end else begin
            park = (i + 1 == script.size()) || (script[i + 1].kind == ROW_CSR);
            send_sample(script[i].bits, script[i].typed, script[i].want, park);
         end
      end

      // random phases, fresh settings each time
      for (int ph = 0; ph < 10; ph++) begin
         quiesce();
         calm = (ph == 3);
         rot = $urandom_range(2);
         for (int k = 0; k < 3; k++) begin
            case (reg_order[(rot + k) % 3])
               CSR_PROP_GAIN:  csr_write(CSR_PROP_GAIN, pick_gain());
               CSR_DERIV_GAIN: csr_write(CSR_DERIV_GAIN, pick_gain());
               default:        csr_write(CSR_BASE_SPEED, pick_base());
            endcase
         end
         if ($urandom_range(2) == 0) csr_write(CSR_UNUSED, GAIN_W'($urandom_range(16'hFFFF)));
         for (int n = 0; n < 190; n++) begin
            // every so often hold off until all results are back
            park = (n == 189) || (n % 64 == 63);
            send_sample(pick_sensors(), 1'b0, '0, park);
            if (park && n != 189) begin
               while (steer_due.size() != 0) @(posedge clock);
            end
         end
      end
      calm = 1'b0;

      while (steer_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (faults == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // hard stop, several times the slowest legal run
   initial begin
      #20_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
